[rtl/core/teod_pkg.sv]
package teod_pkg;

  localparam int CodeWidth     = 21;
  localparam int TabWidthBits  = 6;
  localparam int QueueDepth    = 4;
  localparam int MaxResults    = 64;

  localparam logic [TabWidthBits-1:0] TabWidthReset = 6'd8;
  localparam logic [TabWidthBits-1:0] CountLast     = TabWidthBits'(MaxResults - 1);

  localparam logic [CodeWidth-1:0] ChBs    = 21'd8;
  localparam logic [CodeWidth-1:0] ChTab   = 21'd9;
  localparam logic [CodeWidth-1:0] ChLf    = 21'd10;
  localparam logic [CodeWidth-1:0] ChSpace = 21'd32;
  localparam logic [CodeWidth-1:0] ChPlus  = 21'd43;
  localparam logic [CodeWidth-1:0] ChUnder = 21'd95;
  localparam logic [CodeWidth-1:0] ChO     = 21'd111;

  // What the back part does after the optional flush of the held character
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;
  localparam logic [1:0] KIND_TAB  = 2'd2;
  localparam logic [1:0] KIND_LF   = 2'd3;

  typedef struct packed {
    logic                 flush;
    logic [CodeWidth-1:0] flush_code;
    logic                 flush_bold;
    logic                 flush_underline;
    logic [1:0]           kind;
    logic [CodeWidth-1:0] code;
    logic                 fin;
  } cmd_t;

endpackage

[rtl/core/teod_front.sv]
module teod_front import teod_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [CodeWidth-1:0] in_code,
  input  logic                 in_final,
  output logic                 full,
  input  logic                 q_full,
  output logic                 q_push,
  output cmd_t                 q_data
);

  localparam logic [1:0] MODE_EMPTY = 2'd0;
  localparam logic [1:0] MODE_HELD  = 2'd1;
  localparam logic [1:0] MODE_PEND  = 2'd2;

  logic [1:0]           mode, mode_next;
  logic [CodeWidth-1:0] held_code, held_code_next;
  logic                 held_bold, held_bold_next;
  logic                 held_underline, held_underline_next;
  logic                 accept;
  logic [CodeWidth-1:0] merge_code;
  logic                 merge_bold;
  logic                 merge_underline;
  logic [CodeWidth-1:0] struck_base;

  assign accept = push && !q_full;
  assign full   = q_full;

  // Overstrike merge of the held character with the incoming one
  always_comb begin
    struck_base     = (held_code == ChPlus && in_code == ChO) ? ChO : held_code;
    merge_code      = struck_base;
    merge_bold      = held_bold;
    merge_underline = held_underline;
    priority if (struck_base == ChUnder) begin
      merge_code      = in_code;
      merge_underline = 1'b1;
    end else if (in_code == struck_base) begin
      merge_bold = 1'b1;
    end else if (in_code == ChUnder) begin
      merge_underline = 1'b1;
    end else begin
      merge_code = struck_base;
    end
  end

  always_comb begin
    mode_next           = mode;
    held_code_next      = held_code;
    held_bold_next      = held_bold;
    held_underline_next = held_underline;
    q_push              = 1'b0;
    q_data              = '0;
    q_data.flush_code      = held_code;
    q_data.flush_bold      = held_bold;
    q_data.flush_underline = held_underline;
    q_data.fin             = in_final;
    if (accept) begin
      priority if (mode == MODE_PEND) begin
        held_code_next      = merge_code;
        held_bold_next      = merge_bold;
        held_underline_next = merge_underline;
        mode_next           = MODE_HELD;
        if (in_final) begin
          q_data.flush           = 1'b1;
          q_data.flush_code      = merge_code;
          q_data.flush_bold      = merge_bold;
          q_data.flush_underline = merge_underline;
          q_data.kind            = KIND_NONE;
          q_push                 = 1'b1;
          mode_next              = MODE_EMPTY;
        end
      end else if (in_code == ChBs && mode == MODE_HELD && !in_final) begin
        mode_next = MODE_PEND;
      end else if (in_code == ChTab || in_code == ChLf) begin
        q_data.flush = (mode == MODE_HELD);
        q_data.kind  = (in_code == ChTab) ? KIND_TAB : KIND_LF;
        q_push       = 1'b1;
        mode_next    = MODE_EMPTY;
      end else begin
        q_data.flush        = (mode == MODE_HELD);
        held_code_next      = in_code;
        held_bold_next      = 1'b0;
        held_underline_next = 1'b0;
        mode_next           = MODE_HELD;
        if (in_final) begin
          // flush the new character right away
          q_data.kind = KIND_CHAR;
          q_data.code = in_code;
          q_push      = 1'b1;
          mode_next   = MODE_EMPTY;
        end else begin
          q_data.kind = KIND_NONE;
          q_push      = (mode == MODE_HELD);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_EMPTY;
    end else begin
      mode <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    held_code      <= held_code_next;
    held_bold      <= held_bold_next;
    held_underline <= held_underline_next;
  end

endmodule

[rtl/core/teod_queue.sv]
module teod_queue import teod_pkg::*; #(
  parameter int DEPTH = QueueDepth  // 2 or more
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  output logic rd_valid,
  input  logic rd_en,
  output cmd_t rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

[rtl/core/teod_back.sv]
module teod_back import teod_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [TabWidthBits-1:0] tab_width,
  input  logic                    q_valid,
  input  cmd_t                    q_data,
  output logic                    q_pop,
  input  logic                    pop,
  output logic                    empty,
  output logic [CodeWidth-1:0]    out_code,
  output logic                    out_bold,
  output logic                    out_underline,
  output logic                    run_end,
  output logic                    text_end
);

  logic                    out_valid;
  logic [TabWidthBits-1:0] column;
  logic [TabWidthBits-1:0] count;
  logic                    flush_done;
  logic [TabWidthBits-1:0] col_inc;
  logic [TabWidthBits-1:0] col_adv;
  logic [CodeWidth-1:0]    res_code;
  logic                    res_bold;
  logic                    res_underline;
  logic                    res_last;
  logic                    res_lf;
  logic                    go;

  assign empty = !out_valid;
  assign go    = q_valid && (!out_valid || pop);
  assign q_pop = go && res_last;

  assign col_inc = column + 1'b1;
  assign col_adv = (col_inc >= tab_width) ? '0 : col_inc;

  always_comb begin
    res_code      = q_data.code;
    res_bold      = 1'b0;
    res_underline = 1'b0;
    res_last      = 1'b1;
    res_lf        = 1'b0;
    if (q_data.flush && !flush_done) begin
      res_code      = q_data.flush_code;
      res_bold      = q_data.flush_bold;
      res_underline = q_data.flush_underline;
      res_last      = (q_data.kind == KIND_NONE);
    end else begin
      unique case (q_data.kind)
        KIND_TAB: begin
          res_code = ChSpace;
          res_last = (col_adv == '0) || (count == CountLast);
        end
        KIND_LF: begin
          res_code = ChLf;
          res_lf   = 1'b1;
        end
        KIND_CHAR: res_code = q_data.code;
        default:   res_code = q_data.code;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      column     <= '0;
      count      <= '0;
      flush_done <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
      // line feed and end of text return to column zero
      column <= (res_lf || (res_last && q_data.fin)) ? '0 : col_adv;
      if (res_last) begin
        count      <= '0;
        flush_done <= 1'b0;
      end else begin
        count      <= count + 1'b1;
        flush_done <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_code      <= res_code;
      out_bold      <= res_bold;
      out_underline <= res_underline;
      run_end       <= res_last;
      text_end      <= res_last && q_data.fin;
    end
  end

endmodule

[rtl/core/tab_expand_overstrike_decode.sv]
// Channel   Ports                                          Transaction when
// input     push, full, in_code, in_final                  push && !full
// result    empty, pop, out_code, out_bold, out_underline,  pop && !empty
//           run_end, text_end
// config    cfg_valid, cfg_ready, cfg_tab_width            cfg_valid && cfg_ready
//
// The front takes one character per cycle while the command queue has room.
// The back emits one result per cycle while commands wait and results are
// taken: a plain character gives one result, a tab one per space, and a
// character flushed ahead of a tab, a line feed or a final character one
// more. Tab runs in the back fill the queue and then raise full.
// Reset (rst, synchronous) empties the queue and the output register and sets
// tab_width to 8; there is no clearing pass.
module tab_expand_overstrike_decode import teod_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [CodeWidth-1:0]    in_code,
  input  logic                    in_final,
  output logic                    empty,
  input  logic                    pop,
  output logic [CodeWidth-1:0]    out_code,
  output logic                    out_bold,
  output logic                    out_underline,
  output logic                    run_end,
  output logic                    text_end,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [TabWidthBits-1:0] cfg_tab_width
);

  logic [TabWidthBits-1:0] tab_width;
  logic                    q_full;
  logic                    q_push;
  cmd_t                    q_wr_data;
  logic                    q_valid;
  logic                    q_pop;
  cmd_t                    q_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_width <= TabWidthReset;
    end else if (cfg_valid && cfg_ready) begin
      tab_width <= cfg_tab_width;
    end
  end

  teod_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .in_code  (in_code),
    .in_final (in_final),
    .full     (full),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr_data)
  );

  teod_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_data  (q_rd_data)
  );

  teod_back u_back (
    .clk           (clk),
    .rst           (rst),
    .tab_width     (tab_width),
    .q_valid       (q_valid),
    .q_data        (q_rd_data),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .out_code      (out_code),
    .out_bold      (out_bold),
    .out_underline (out_underline),
    .run_end       (run_end),
    .text_end      (text_end)
  );

endmodule

[rtl/core/teod_checker.sv]
module teod_checker import teod_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    push,
  input logic                    full,
  input logic [CodeWidth-1:0]    in_code,
  input logic                    in_final,
  input logic                    empty,
  input logic                    pop,
  input logic [CodeWidth-1:0]    out_code,
  input logic                    out_bold,
  input logic                    out_underline,
  input logic                    run_end,
  input logic                    text_end,
  input logic                    cfg_valid,
  input logic                    cfg_ready,
  input logic [TabWidthBits-1:0] cfg_tab_width
);

  // hold a waiting result until it is taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_code) && $stable(out_bold)
      && $stable(out_underline) && $stable(run_end) && $stable(text_end))
    else $error("result changed while stalled");

  // the last result of the text also closes its item
  a_text_end_run_end: assert property (@(posedge clk) disable iff (rst)
    !empty && text_end |-> run_end)
    else $error("text_end without run_end");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queue not empty after reset");

  a_result_known: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !$isunknown({out_code, out_bold, out_underline, run_end, text_end}))
    else $error("result carries unknown bits");

  a_input_known: assert property (@(posedge clk) disable iff (rst)
    (push && !full) || (cfg_valid && cfg_ready)
      |-> !$isunknown({in_code, in_final, cfg_tab_width}))
    else $error("transaction carries unknown bits");

endmodule

bind tab_expand_overstrike_decode teod_checker u_teod_checker (.*);
